// ===== rtl/upm_pkg.sv =====
// ----------------------------------------------------------------------------
// upm_pkg
// Shared types, codes and helper functions of the USB host pipe table.
// ----------------------------------------------------------------------------
package upm_pkg;

	localparam int PIPE_COUNT_DEF = 8;

	localparam logic [7:0]  FREE_MARK  = 8'hFF;
	localparam logic [1:0]  EV_SUCCESS = 2'd0;

	localparam logic [1:0]  TOK_SETUP = 2'd0;
	localparam logic [1:0]  TOK_IN    = 2'd1;
	localparam logic [1:0]  TOK_OUT   = 2'd2;

	typedef enum logic [2:0] {
		OP_OPEN   = 3'd0,
		OP_SUBMIT = 3'd1,
		OP_EVENT  = 3'd2,
		OP_ABORT  = 3'd3,
		OP_CLOSE  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_READ,
		ST_EXEC,
		ST_EV2
	} state_t;

	typedef struct packed {
		logic [7:0]  dev;
		logic [7:0]  ep;
		logic [10:0] mps;
		logic [15:0] done;
		logic [15:0] rem;
		logic        act;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		dev:  FREE_MARK,
		ep:   FREE_MARK,
		mps:  11'd0,
		done: 16'd0,
		rem:  16'd0,
		act:  1'b0
	};

	typedef struct packed {
		logic        ok;
		logic [2:0]  pipe_used;
		logic [1:0]  token_kind;
		logic [2:0]  size_code;
		logic        done_res;
		logic [15:0] bytes_done;
		logic [10:0] next_len;
		logic [7:0]  owner_device;
		logic [7:0]  owner_endpoint;
	} res_t;

	typedef struct packed {
		logic hit;
		logic free;
	} scan_t;

	typedef struct packed {
		logic [15:0] delta;
		logic [15:0] rem;
		logic [15:0] done;
	} acct_t;

	function automatic logic [1:0] token_of(input logic [7:0] ep);
		logic [1:0] t;
		if (ep[7])
			t = TOK_IN;
		else if (ep[6:0] == 7'd0)
			t = TOK_SETUP;
		else
			t = TOK_OUT;
		return t;
	endfunction

	function automatic logic [2:0] size_code_of(input logic [10:0] m);
		logic [2:0] c;
		if (m >= 11'd1023)
			c = 3'd7;
		else if (m > 11'd256)
			c = 3'd6;
		else if (m > 11'd128)
			c = 3'd5;
		else if (m > 11'd64)
			c = 3'd4;
		else if (m > 11'd32)
			c = 3'd3;
		else if (m > 11'd16)
			c = 3'd2;
		else if (m > 11'd8)
			c = 3'd1;
		else
			c = 3'd0;
		return c;
	endfunction

endpackage

// ===== rtl/usb_host_pipe_manager.sv =====
// ----------------------------------------------------------------------------
// usb_host_pipe_manager
// USB host pipe table: open, submit, transfer event, abort and close device.
// ----------------------------------------------------------------------------
// channel   handshake          payload
// command   start / busy       opcode .. packet_bytes
// result    strobe (1 cycle)   ok .. owner_endpoint
//
// states from the accepting edge to the result beat, in order:
// open, submit, abort: scan, drain, pick, read, exec, or up to pick
// with no pipe found; close: scan, drain, pick; transfer event: read,
// exec, ev2 (not on a free pipe); unknown opcode, out-of-range event: idle.
// the table is scanned one entry per cycle through its single read port.
// reset clears the per-entry valid bits at once; no clearing pass.
// busy is low during the strobe cycle, so the next command may start then.
// the receiver cannot stall the result.
// ----------------------------------------------------------------------------
module usb_host_pipe_manager #(
	parameter int PIPE_COUNT = upm_pkg::PIPE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [6:0]  device_address,
	input  logic [7:0]  endpoint_address,
	input  logic [10:0] max_packet,
	input  logic [15:0] transfer_len,
	input  logic [2:0]  pipe_index,
	input  logic [1:0]  event_code,
	input  logic [13:0] packet_bytes,
	output logic        strobe,
	output logic        ok,
	output logic [2:0]  pipe_used,
	output logic [1:0]  token_kind,
	output logic [2:0]  size_code,
	output logic        done_res,
	output logic [15:0] bytes_done,
	output logic [10:0] next_len,
	output logic [7:0]  owner_device,
	output logic [7:0]  owner_endpoint
);

	localparam int IDX_W = $clog2(PIPE_COUNT);
	localparam int EXT_W = IDX_W + 3;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(PIPE_COUNT - 1);

	upm_pkg::state_t  state_q, state_n;
	upm_pkg::op_t     op_q;
	logic [6:0]       dev_q;
	logic [7:0]       ep_q;
	logic [10:0]      mps_q;
	logic [15:0]      len_q;
	logic [1:0]       code_q;
	logic [13:0]      pkt_q;

	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] chk_idx_q;
	logic             chk_q;
	logic             hit_q;
	logic             fre_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] fre_idx_q;
	logic [IDX_W-1:0] target_q;
	upm_pkg::acct_t   acct_q;
	upm_pkg::res_t    res_q;
	logic             strobe_q;

	logic [IDX_W-1:0] rd_addr;
	upm_pkg::entry_t  rd_ent;
	logic             wr_en;
	logic             clr_en;
	logic             fin;
	upm_pkg::res_t    res_n;
	logic             ev_in_range;
	logic [EXT_W-1:0] pidx_ext;
	logic [EXT_W-1:0] tgt_ext;
	logic [EXT_W-1:0] hit_ext;

	upm_pkg::scan_t   scan;
	logic             ent_free;
	upm_pkg::acct_t   acct_n;
	logic             u_wr;
	upm_pkg::entry_t  wr_ent;
	upm_pkg::res_t    u_res;

	assign ev_in_range = int'(pipe_index) < PIPE_COUNT;
	assign pidx_ext    = EXT_W'(pipe_index);
	assign tgt_ext     = EXT_W'(target_q);
	assign hit_ext     = EXT_W'(hit_idx_q);

	upm_table #(
		.PIPE_COUNT(PIPE_COUNT)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_ent   (rd_ent),
		.wr_en    (wr_en),
		.wr_addr  (target_q),
		.wr_ent   (wr_ent),
		.clr_en   (clr_en),
		.clr_addr (chk_idx_q)
	);

	upm_unit u_unit (
		.op       (op_q),
		.dev      (dev_q),
		.ep       (ep_q),
		.mps      (mps_q),
		.len      (len_q),
		.code     (code_q),
		.pkt      (pkt_q),
		.pipe     (tgt_ext[2:0]),
		.ent      (rd_ent),
		.acct_in  (acct_q),
		.scan     (scan),
		.ent_free (ent_free),
		.acct_out (acct_n),
		.wr       (u_wr),
		.wr_ent   (wr_ent),
		.res      (u_res)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			upm_pkg::ST_IDLE: begin
				if (start) begin
					case (upm_pkg::op_t'(opcode))
						upm_pkg::OP_OPEN, upm_pkg::OP_SUBMIT,
						upm_pkg::OP_ABORT, upm_pkg::OP_CLOSE:
							state_n = upm_pkg::ST_SCAN;
						upm_pkg::OP_EVENT:
							state_n = ev_in_range ? upm_pkg::ST_READ : upm_pkg::ST_IDLE;
						default:
							state_n = upm_pkg::ST_IDLE;
					endcase
				end
			end
			upm_pkg::ST_SCAN: begin
				if (scan_q == LAST)
					state_n = upm_pkg::ST_DRAIN;
			end
			upm_pkg::ST_DRAIN: begin
				state_n = upm_pkg::ST_PICK;
			end
			upm_pkg::ST_PICK: begin
				case (op_q)
					upm_pkg::OP_ABORT:
						state_n = hit_q ? upm_pkg::ST_READ : upm_pkg::ST_IDLE;
					upm_pkg::OP_OPEN, upm_pkg::OP_SUBMIT:
						state_n = (hit_q || fre_q) ? upm_pkg::ST_READ : upm_pkg::ST_IDLE;
					default:
						state_n = upm_pkg::ST_IDLE;
				endcase
			end
			upm_pkg::ST_READ: begin
				state_n = upm_pkg::ST_EXEC;
			end
			upm_pkg::ST_EXEC: begin
				if (op_q == upm_pkg::OP_EVENT && !ent_free)
					state_n = upm_pkg::ST_EV2;
				else
					state_n = upm_pkg::ST_IDLE;
			end
			upm_pkg::ST_EV2: begin
				state_n = upm_pkg::ST_IDLE;
			end
			default: begin
				state_n = upm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_addr = (state_q == upm_pkg::ST_SCAN) ? scan_q : target_q;
		clr_en  = chk_q && (op_q == upm_pkg::OP_CLOSE) && scan.hit;
		wr_en   = 1'b0;
		fin     = 1'b0;
		res_n   = '0;
		case (state_q)
			upm_pkg::ST_IDLE: begin
				if (start && state_n == upm_pkg::ST_IDLE)
					fin = 1'b1;
			end
			upm_pkg::ST_PICK: begin
				if (state_n == upm_pkg::ST_IDLE) begin
					fin = 1'b1;
					if (op_q == upm_pkg::OP_CLOSE && hit_q) begin
						res_n.ok        = 1'b1;
						res_n.pipe_used = hit_ext[2:0];
					end
				end
			end
			upm_pkg::ST_EXEC: begin
				if (op_q != upm_pkg::OP_EVENT) begin
					fin   = 1'b1;
					wr_en = u_wr;
					res_n = u_res;
				end else if (ent_free) begin
					fin = 1'b1;
				end
			end
			upm_pkg::ST_EV2: begin
				fin   = 1'b1;
				wr_en = u_wr;
				res_n = u_res;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= upm_pkg::ST_IDLE;
			scan_q   <= '0;
			chk_q    <= 1'b0;
			hit_q    <= 1'b0;
			fre_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			strobe_q <= fin;
			chk_q    <= (state_q == upm_pkg::ST_SCAN);
			if (state_q == upm_pkg::ST_IDLE) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				fre_q  <= 1'b0;
			end else if (state_q == upm_pkg::ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			if (chk_q) begin
				if (scan.hit && !hit_q)
					hit_q <= 1'b1;
				if (scan.free && !fre_q)
					fre_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_q <= scan_q;
		if (chk_q) begin
			if (scan.hit && !hit_q)
				hit_idx_q <= chk_idx_q;
			if (scan.free && !fre_q)
				fre_idx_q <= chk_idx_q;
		end
		if (state_q == upm_pkg::ST_IDLE && start) begin
			op_q     <= upm_pkg::op_t'(opcode);
			dev_q    <= device_address;
			ep_q     <= endpoint_address;
			mps_q    <= max_packet;
			len_q    <= transfer_len;
			code_q   <= event_code;
			pkt_q    <= packet_bytes;
			target_q <= pidx_ext[IDX_W-1:0];
		end else if (state_q == upm_pkg::ST_PICK) begin
			target_q <= hit_q ? hit_idx_q : fre_idx_q;
		end
		if (state_q == upm_pkg::ST_EXEC)
			acct_q <= acct_n;
		if (fin)
			res_q <= res_n;
	end

	assign busy           = (state_q != upm_pkg::ST_IDLE);
	assign strobe         = strobe_q;
	assign ok             = res_q.ok;
	assign pipe_used      = res_q.pipe_used;
	assign token_kind     = res_q.token_kind;
	assign size_code      = res_q.size_code;
	assign done_res       = res_q.done_res;
	assign bytes_done     = res_q.bytes_done;
	assign next_len       = res_q.next_len;
	assign owner_device   = res_q.owner_device;
	assign owner_endpoint = res_q.owner_endpoint;

endmodule

// ===== rtl/upm_table.sv =====
// ----------------------------------------------------------------------------
// upm_table
// Pipe entry memory, one read and one write port, with per-entry valid bits.
// ----------------------------------------------------------------------------
module upm_table #(
	parameter int PIPE_COUNT = upm_pkg::PIPE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(PIPE_COUNT)-1:0]   rd_addr,
	output upm_pkg::entry_t                 rd_ent,
	input  logic                            wr_en,
	input  logic [$clog2(PIPE_COUNT)-1:0]   wr_addr,
	input  upm_pkg::entry_t                 wr_ent,
	input  logic                            clr_en,
	input  logic [$clog2(PIPE_COUNT)-1:0]   clr_addr
);

	upm_pkg::entry_t         mem_q [PIPE_COUNT];
	upm_pkg::entry_t         data_q;
	logic [PIPE_COUNT-1:0]   vld_q;
	logic                    rdv_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_ent;
		data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			rdv_q <= vld_q[rd_addr];
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (clr_en)
				vld_q[clr_addr] <= 1'b0;
		end
	end

	// never-written entries read as a free pipe
	assign rd_ent = rdv_q ? data_q : upm_pkg::ENTRY_RESET;

endmodule

// ===== rtl/upm_unit.sv =====
// ----------------------------------------------------------------------------
// upm_unit
// Shared compare and accounting unit: entry match during the scan, entry
// update and result for the selected pipe.
// ----------------------------------------------------------------------------
module upm_unit (
	input  upm_pkg::op_t    op,
	input  logic [6:0]      dev,
	input  logic [7:0]      ep,
	input  logic [10:0]     mps,
	input  logic [15:0]     len,
	input  logic [1:0]      code,
	input  logic [13:0]     pkt,
	input  logic [2:0]      pipe,
	input  upm_pkg::entry_t ent,
	input  upm_pkg::acct_t  acct_in,
	output upm_pkg::scan_t  scan,
	output logic            ent_free,
	output upm_pkg::acct_t  acct_out,
	output logic            wr,
	output upm_pkg::entry_t wr_ent,
	output upm_pkg::res_t   res
);

	logic        dev_eq;
	logic        num_eq;
	logic [15:0] delta0;
	logic        short_pkt;
	logic [15:0] rem2;
	logic        complete;
	logic [10:0] nl_ev;

	assign dev_eq   = (ent.dev == {1'b0, dev});
	assign num_eq   = (ent.ep[6:0] == ep[6:0]);
	assign ent_free = (ent.dev == upm_pkg::FREE_MARK);

	always_comb begin
		scan.free = ent_free;
		case (op)
			upm_pkg::OP_OPEN, upm_pkg::OP_SUBMIT:
				scan.hit = num_eq && (dev_eq || ep[6:0] == 7'd0);
			upm_pkg::OP_ABORT:
				scan.hit = dev_eq && (ent.ep == ep);
			upm_pkg::OP_CLOSE:
				scan.hit = dev_eq;
			default:
				scan.hit = 1'b0;
		endcase
	end

	// first half of event accounting: clamp, subtract, accumulate
	always_comb begin
		delta0 = (code == upm_pkg::EV_SUCCESS) ? {2'b00, pkt} : 16'd0;
		acct_out.delta = (delta0 > ent.rem) ? ent.rem : delta0;
		acct_out.rem   = ent.rem - acct_out.delta;
		acct_out.done  = ent.done + acct_out.delta;
	end

	// second half: short packet, completion, next length
	assign short_pkt = acct_in.delta < {5'd0, ent.mps};
	assign rem2      = short_pkt ? 16'd0 : acct_in.rem;
	assign complete  = (code != upm_pkg::EV_SUCCESS) || (rem2 == 16'd0);
	assign nl_ev     = (acct_in.rem < {5'd0, ent.mps}) ? acct_in.rem[10:0] : ent.mps;

	always_comb begin
		wr     = 1'b0;
		wr_ent = ent;
		res    = '0;
		case (op)
			upm_pkg::OP_OPEN: begin
				if (!ent.act) begin
					wr            = 1'b1;
					wr_ent.dev    = {1'b0, dev};
					wr_ent.ep     = ep;
					wr_ent.mps    = mps;
					res.ok        = 1'b1;
					res.size_code = upm_pkg::size_code_of(mps);
				end
			end
			upm_pkg::OP_SUBMIT: begin
				if (!ent.act) begin
					wr          = 1'b1;
					wr_ent.dev  = {1'b0, dev};
					wr_ent.ep   = ep;
					wr_ent.rem  = len;
					wr_ent.done = 16'd0;
					wr_ent.act  = 1'b1;
					res.ok      = 1'b1;
					if (ep[7])
						res.next_len = 11'd0;
					else if (len < {5'd0, ent.mps})
						res.next_len = len[10:0];
					else
						res.next_len = ent.mps;
				end
			end
			upm_pkg::OP_EVENT: begin
				wr           = 1'b1;
				wr_ent.rem   = rem2;
				wr_ent.done  = acct_in.done;
				wr_ent.act   = !complete;
				res.ok       = 1'b1;
				res.done_res = complete;
				res.next_len = (complete || ent.ep[7]) ? 11'd0 : nl_ev;
			end
			upm_pkg::OP_ABORT: begin
				wr = 1'b1;
				if (ent.act) begin
					wr_ent.act  = 1'b0;
					wr_ent.done = 16'd0;
					wr_ent.rem  = 16'd0;
					res.ok      = 1'b1;
				end
			end
			default: begin
				wr = 1'b0;
			end
		endcase
		if (wr) begin
			res.pipe_used      = pipe;
			res.token_kind     = upm_pkg::token_of(wr_ent.ep);
			res.bytes_done     = wr_ent.done;
			res.owner_device   = wr_ent.dev;
			res.owner_endpoint = wr_ent.ep;
		end
	end

endmodule

// ===== rtl/upm_checker.sv =====
// ----------------------------------------------------------------------------
// upm_checker
// Port-level checks of the pipe table command and result beats.
// ----------------------------------------------------------------------------
module upm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic        ok,
	input logic        done_res,
	input logic [2:0]  size_code,
	input logic [10:0] next_len
);

	// result beat only at the end of a busy stretch or right after accept
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result beat while busy");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || strobe))
		else $error("accepted beat neither worked on nor answered");

	a_strobe_cause: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(busy) || $past(start)))
		else $error("result beat without a command");

	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && done_res) |-> ok)
		else $error("completion on a failed beat");

	a_open_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && size_code != 3'd0) |-> (ok && !done_res && next_len == 11'd0))
		else $error("size code on a beat that is not an open");

endmodule

bind usb_host_pipe_manager upm_checker u_upm_checker (.*);
